/* hw/rtl/bls_pkg.sv */
package bls_pkg;

  localparam int WORD_W = 32;

  typedef logic [1:0]               mode_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam mode_t MODE_PUSH = 2'd0;
  localparam mode_t MODE_POP  = 2'd1;
  localparam mode_t MODE_PEEK = 2'd2;
  localparam mode_t MODE_DUMP = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_OVER  = 2'd1;
  localparam status_t STATUS_UNDER = 2'd2;

endpackage

/* hw/rtl/bls_if.sv */
interface bls_in_if import bls_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  word_t push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface bls_out_if import bls_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   data;
  logic    is_empty;
  logic    is_full;
  logic    last;

  modport source (output valid, output status, output data, output is_empty,
                  output is_full, output last, input ready);
  modport sink   (input valid, input status, input data, input is_empty,
                  input is_full, input last, output ready);
endinterface

/* hw/rtl/bls_ram.sv */
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bounded_lifo_stack.sv */
// Channel   Port    Direction  Transaction
// -------   ------  ---------  -------------------------------------------
// in        in_ch   sink       mode, push_value: one operation
// out       out_ch  source     status, data, is_empty, is_full, last
//
// An accepted operation is held in the operation registers while the entry memory
// makes its registered read, then moves to the output register once it is free.
// Push, pop and peek sustain one transaction per cycle while out_ch is ready.
// Dump gives one result per cycle per stored entry while out_ch is ready, one memory read each.
// rst_n (synchronous) empties the stack; memory contents are not cleared.
// A stalled output holds the result and the pending memory read word.
module bounded_lifo_stack import bls_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_in_if.sink    in_ch,
  bls_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  mode_t         op_r, op_nxt;
  word_t         val_r, val_nxt;
  logic          err_r, err_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  word_t   out_data_r, out_data_nxt;
  logic    out_empty_r, out_empty_nxt;
  logic    out_full_r, out_full_nxt;
  logic    out_last_r, out_last_nxt;

  logic              slot_free, emit_fire, emit_last;
  logic              in_ready, in_fire;
  logic              is_full_now, is_empty_now;
  logic [CW-1:0]     cnt_dec;
  logic [AW-1:0]     top_addr;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  always_comb begin
    slot_free    = !out_valid_r || out_ch.ready;
    emit_fire    = (state_r == ST_EMIT) && slot_free;
    emit_last    = err_r || (op_r != MODE_DUMP) || (idx_r == '0);
    in_ready     = (state_r == ST_IDLE) || (emit_fire && emit_last);
    in_fire      = in_ch.valid && in_ready;
    is_full_now  = (count_r == CW'(DEPTH));
    is_empty_now = (count_r == '0);
    cnt_dec      = count_r - CW'(1);
    top_addr     = cnt_dec[AW-1:0];
  end

  assign in_ch.ready = in_ready;

  // accept side: decide the operation, update the count, start the read or write, step a dump
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    err_nxt   = err_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = top_addr;

    if (emit_fire) begin
      if (emit_last) begin
        state_nxt = ST_IDLE;
      end else begin
        // advance the dump to the next entry down
        idx_nxt   = idx_r - AW'(1);
        ram_re    = 1'b1;
        ram_raddr = idx_r - AW'(1);
      end
    end

    if (in_fire) begin
      state_nxt = ST_EMIT;
      op_nxt    = in_ch.mode;
      val_nxt   = in_ch.push_value;
      idx_nxt   = top_addr;
      case (in_ch.mode)
        MODE_PUSH: begin
          err_nxt = is_full_now;
          if (!is_full_now) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_POP: begin
          err_nxt = is_empty_now;
          if (!is_empty_now) begin
            ram_re    = 1'b1;
            ram_raddr = top_addr;
            count_nxt = cnt_dec;
          end
        end
        default: begin
          err_nxt = is_empty_now;
          if (!is_empty_now) begin
            ram_re    = 1'b1;
            ram_raddr = top_addr;
          end
        end
      endcase
    end
  end

  // result side
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    out_last_nxt   = out_last_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = is_empty_now;
      out_full_nxt  = is_full_now;
      out_last_nxt  = emit_last;
      if (op_r == MODE_PUSH) begin
        out_status_nxt = err_r ? STATUS_OVER : STATUS_OK;
        out_data_nxt   = val_r;
      end else if (err_r) begin
        out_status_nxt = STATUS_UNDER;
        out_data_nxt   = '0;
      end else begin
        out_status_nxt = STATUS_OK;
        out_data_nxt   = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    err_r        <= err_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    out_last_r   <= out_last_nxt;
  end

  bls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_ch.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.data     = out_data_r;
  assign out_ch.is_empty = out_empty_r;
  assign out_ch.is_full  = out_full_r;
  assign out_ch.last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stack count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + CW'(1)))
    else $error("accepted push did not grow the stack by one");

  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_OVER) |-> (out_full_r && !out_empty_r))
    else $error("overflow reported on a stack that is not full");

  a_no_accept_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !emit_last) |-> !in_ready)
    else $error("new transaction taken while a dump is still running");

endmodule

/* tb/sv/bounded_lifo_stack_tb.sv */
module bounded_lifo_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam int STACK_DEPTH    = 64;
  localparam int RANDOM_ITEMS   = 410;
  localparam int IDLE_PCT       = 35;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int N_DIRECTED     = 20;

  localparam int SEG_FILL  = 0;
  localparam int SEG_DRAIN = 1;
  localparam int SEG_MIX   = 2;

  typedef struct packed {
    status_t status;
    word_t   data;
    logic    is_empty;
    logic    is_full;
    logic    last;
  } stack_result_t;

  typedef struct packed {
    mode_t         mode;
    word_t         value;
    logic          typed;
    stack_result_t res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bls_in_if  in_ch ();
  bls_out_if out_ch ();

  bounded_lifo_stack #(.DEPTH(STACK_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow stack and the results it says the block owes us.
  word_t         model_entries [STACK_DEPTH];
  int            model_count = 0;
  stack_result_t expected_results [$];

  int err_count     = 0;
  int hold_requests = 0;
  int quiet_cycles  = 0;
  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;

  // Rows with typed = 1 carry their expected result; the rest use the predictor.
  op_row_t directed_ops [N_DIRECTED] = '{
    '{MODE_POP,  32'h0000_0000, 1'b1, '{STATUS_UNDER, 32'h0000_0000, 1'b1, 1'b0, 1'b1}},
    '{MODE_PEEK, 32'h0000_0000, 1'b1, '{STATUS_UNDER, 32'h0000_0000, 1'b1, 1'b0, 1'b1}},
    '{MODE_DUMP, 32'h0000_0000, 1'b1, '{STATUS_UNDER, 32'h0000_0000, 1'b1, 1'b0, 1'b1}},
    '{MODE_PUSH, 32'h7fff_ffff, 1'b1, '{STATUS_OK,    32'h7fff_ffff, 1'b0, 1'b0, 1'b1}},
    '{MODE_PUSH, 32'h8000_0000, 1'b1, '{STATUS_OK,    32'h8000_0000, 1'b0, 1'b0, 1'b1}},
    '{MODE_PEEK, 32'h0000_0000, 1'b1, '{STATUS_OK,    32'h8000_0000, 1'b0, 1'b0, 1'b1}},
    '{MODE_DUMP, 32'h0000_0000, 1'b0, '0},
    '{MODE_POP,  32'h0000_0000, 1'b1, '{STATUS_OK,    32'h8000_0000, 1'b0, 1'b0, 1'b1}},
    '{MODE_POP,  32'h0000_0000, 1'b1, '{STATUS_OK,    32'h7fff_ffff, 1'b1, 1'b0, 1'b1}},
    '{MODE_POP,  32'hffff_ffff, 1'b1, '{STATUS_UNDER, 32'h0000_0000, 1'b1, 1'b0, 1'b1}},
    '{MODE_PUSH, 32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0000_0000, 1'b0, 1'b0, 1'b1}},
    '{MODE_PUSH, 32'hffff_ffff, 1'b1, '{STATUS_OK,    32'hffff_ffff, 1'b0, 1'b0, 1'b1}},
    '{MODE_PUSH, 32'h5555_5555, 1'b0, '0},
    '{MODE_PUSH, 32'haaaa_aaaa, 1'b0, '0},
    '{MODE_PEEK, 32'h0000_0000, 1'b0, '0},
    '{MODE_DUMP, 32'h0000_0000, 1'b0, '0},
    '{MODE_POP,  32'h0000_0000, 1'b0, '0},
    '{MODE_PEEK, 32'h1234_5678, 1'b0, '0},
    '{MODE_DUMP, 32'hffff_ffff, 1'b0, '0},
    '{MODE_POP,  32'h0000_0000, 1'b0, '0}
  };

  function automatic stack_result_t make_result(status_t st, word_t d, logic lst);
    stack_result_t r;
    r.status   = st;
    r.data     = d;
    r.is_empty = (model_count == 0);
    r.is_full  = (model_count >= STACK_DEPTH);
    r.last     = lst;
    return r;
  endfunction

  function automatic void predict_stack_op(mode_t m, word_t v);
    case (m)
      MODE_PUSH: begin
        if (model_count >= STACK_DEPTH) begin
          expected_results.push_back(make_result(STATUS_OVER, v, 1'b1));
        end else begin
          model_entries[model_count] = v;
          model_count++;
          expected_results.push_back(make_result(STATUS_OK, v, 1'b1));
        end
      end
      MODE_POP: begin
        if (model_count == 0) begin
          expected_results.push_back(make_result(STATUS_UNDER, '0, 1'b1));
        end else begin
          model_count--;
          expected_results.push_back(make_result(STATUS_OK, model_entries[model_count], 1'b1));
        end
      end
      MODE_PEEK: begin
        if (model_count == 0) begin
          expected_results.push_back(make_result(STATUS_UNDER, '0, 1'b1));
        end else begin
          expected_results.push_back(make_result(STATUS_OK, model_entries[model_count-1], 1'b1));
        end
      end
      default: begin
        if (model_count == 0) begin
          expected_results.push_back(make_result(STATUS_UNDER, '0, 1'b1));
        end else begin
          // Top down, last flag on the bottom entry.
          for (int i = model_count - 1; i >= 0; i--) begin
            expected_results.push_back(make_result(STATUS_OK, model_entries[i], i == 0));
          end
        end
      end
    endcase
  endfunction

  function automatic void compare_result(stack_result_t want, stack_result_t got);
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, got.status);
      err_count++;
    end
    if (got.data !== want.data) begin
      $display("%0t: data mismatch: expected %0d, actual %0d", $time, want.data, got.data);
      err_count++;
    end
    if (got.is_empty !== want.is_empty) begin
      $display("%0t: is_empty mismatch: expected %b, actual %b", $time, want.is_empty,
               got.is_empty);
      err_count++;
    end
    if (got.is_full !== want.is_full) begin
      $display("%0t: is_full mismatch: expected %b, actual %b", $time, want.is_full,
               got.is_full);
      err_count++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
      err_count++;
    end
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0:       return (($urandom_range(1) == 0) ? 32'h7fff_ffff : 32'h8000_0000);
      1:       return (($urandom_range(1) == 0) ? 32'h0000_0000 : 32'hffff_ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic mode_t pick_mode(int kind);
    int roll;
    roll = $urandom_range(99);
    if (kind == SEG_FILL) begin
      if (roll < 85)      return MODE_PUSH;
      else if (roll < 90) return MODE_POP;
      else if (roll < 95) return MODE_PEEK;
      else                return MODE_DUMP;
    end else if (kind == SEG_DRAIN) begin
      if (roll < 15)      return MODE_PUSH;
      else if (roll < 75) return MODE_POP;
      else if (roll < 90) return MODE_PEEK;
      else                return MODE_DUMP;
    end else begin
      if (roll < 35)      return MODE_PUSH;
      else if (roll < 65) return MODE_POP;
      else if (roll < 85) return MODE_PEEK;
      else                return MODE_DUMP;
    end
  endfunction

  // Offer one operation, hold it until the transaction, then predict.
  task automatic issue_op(mode_t m, word_t v, logic typed, stack_result_t typed_res);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.push_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predict_stack_op(m, v);
    if (typed) begin
      expected_results[expected_results.size()-1] = typed_res;
    end
  endtask

  // Result side: check each transaction, then choose ready for the next cycle.
  initial begin
    int            holds_done;
    int            hold_left;
    stack_result_t got;
    holds_done = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.data, out_ch.is_empty, out_ch.is_full, out_ch.last};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d data %0d",
                   $time, got.status, got.data);
          err_count++;
        end else begin
          compare_result(expected_results.pop_front(), got);
        end
      end
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int seg;
    int sent;
    int kind;
    int len;
    seg  = 0;
    sent = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_PUSH;
    in_ch.push_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      issue_op(directed_ops[i].mode, directed_ops[i].value, directed_ops[i].typed,
               directed_ops[i].res);
    end

    // Stall the output while pushes keep coming, so the input backs up.
    hold_requests++;
    while (sent < RANDOM_ITEMS) begin
      kind = (seg == 0) ? SEG_FILL : $urandom_range(SEG_MIX);
      case (kind)
        SEG_FILL:  len = $urandom_range(100, 70);
        SEG_DRAIN: len = $urandom_range(70, 30);
        default:   len = $urandom_range(30, 10);
      endcase
      tx_steady = (seg == 3 || seg == 4);
      rx_steady = tx_steady;
      if (seg == 6) hold_requests++;
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        issue_op(pick_mode(kind), rand_word(), 1'b0, '0);
        sent++;
      end
      seg++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
